// ----- sv/masf_pkg.sv -----
`default_nettype none

package masf_pkg;

    localparam int POS_BITS_DEF = 16;

    // Character codes used by the scanner
    localparam logic [15:0] AT_CODE     = 16'd64;
    localparam logic [15:0] DOT_CODE    = 16'd46;
    localparam logic [15:0] TILDE_CODE  = 16'd126;
    localparam logic [15:0] LOWER_A     = 16'd97;
    localparam logic [15:0] LOWER_Z     = 16'd122;
    localparam logic [15:0] UNDER_CODE  = 16'd95;
    localparam logic [15:0] UPPER_A     = 16'd65;
    localparam logic [15:0] UPPER_Z     = 16'd90;
    localparam logic [15:0] BSLASH_CODE = 16'd92;
    localparam logic [15:0] DASH_CODE   = 16'd45;
    localparam logic [15:0] COLON_CODE  = 16'd58;
    localparam logic [15:0] EQUAL_CODE  = 16'd61;
    localparam logic [15:0] DOLLAR_CODE = 16'd36;
    localparam logic [15:0] AMP_CODE    = 16'd38;
    localparam logic [15:0] HASH_CODE   = 16'd35;
    localparam logic [15:0] PLUS_CODE   = 16'd43;

    typedef struct packed {
        logic [15:0] char_code;
        logic        line_end;
    } char_word_t;

    typedef struct packed {
        logic        found;
        logic [15:0] match_begin;
        logic [15:0] match_end;
    } result_word_t;

    function automatic logic is_mail(input logic [15:0] c);
        return (c == TILDE_CODE) || ((c >= LOWER_A) && (c <= LOWER_Z)) ||
               (c == UNDER_CODE) || ((c >= UPPER_A) && (c <= UPPER_Z)) ||
               (c == BSLASH_CODE) || ((c >= DASH_CODE) && (c <= COLON_CODE)) ||
               (c == EQUAL_CODE) || ((c >= DOLLAR_CODE) && (c <= AMP_CODE)) ||
               (c == HASH_CODE) || (c == PLUS_CODE);
    endfunction

endpackage

`default_nettype wire

// ----- sv/masf_intf.sv -----
`default_nettype none

interface masf_char_if;
    logic        valid;
    logic        ready;
    logic [15:0] char_code;
    logic        line_end;

    modport source (output valid, output char_code, output line_end, input ready);
    modport sink   (input valid, input char_code, input line_end, output ready);
endinterface

interface masf_result_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [15:0] match_begin;
    logic [15:0] match_end;

    modport source (output valid, output found, output match_begin, output match_end,
                    input ready);
    modport sink   (input valid, input found, input match_begin, input match_end,
                    output ready);
endinterface

interface masf_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/mail_address_span_finder_core.sv -----
`default_nettype none

// Mail address span finder.
// chars:   one 16-bit character word per handshake, position 0 first;
//          line_end marks the last word of a line.
// results: one word per line: found=1 with match_begin/match_end of the
//          first mail span whose '@' sits at or past scan_start, or found=0
//          (positions 0) at line end. Words after a hit give nothing.
// cfg:     writes scan_start; always ready. Write only while idle.
// Path:    a word is registered at accept in the input register and
//          evaluated by the combinational scan step; when the step retires,
//          its result goes into the output register that drives results.
// Throughput: one character per cycle unless a result is held up;
//          the scan step sits between the input and result registers.
// Stall: a result waiting on results holds in the output register; words
//          that make no result keep flowing; chars.ready drops while the
//          input register holds a word whose result cannot be loaded.
// Reset: rst_n (async, active low) clears all line state and scan_start.
module mail_address_span_finder_core
    import masf_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    masf_char_if.sink    chars,
    masf_result_if.source results,
    masf_cfg_if.sink     cfg
);

    logic [15:0]  scan_start_reg;
    logic         s1_valid;
    char_word_t   s1_word;
    char_word_t   in_word;
    logic         s1_advance;
    logic         has_result;
    result_word_t step_result;
    logic         out_valid;
    result_word_t out_word;
    logic         in_accept;

    // config register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_start_reg <= '0;
        end
        else if (cfg.valid)
        begin
            scan_start_reg <= cfg.data;
        end
    end

    // scan step may retire unless it makes a result and the output slot is busy
    assign s1_advance  = s1_valid & (~has_result | ~out_valid | results.ready);
    assign chars.ready = ~s1_valid | s1_advance;
    assign in_accept   = chars.valid & chars.ready;

    assign in_word.char_code = chars.char_code;
    assign in_word.line_end  = chars.line_end;

    masf_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (in_accept),
        .load_word  (in_word),
        .advance    (s1_advance),
        .word_valid (s1_valid),
        .word       (s1_word)
    );

    masf_scan #(
        .POS_BITS (POS_BITS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (s1_valid),
        .word       (s1_word),
        .scan_start (scan_start_reg),
        .advance    (s1_advance),
        .has_result (has_result),
        .result     (step_result)
    );

    masf_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (s1_advance & has_result),
        .load_word  (step_result),
        .take       (results.ready),
        .word_valid (out_valid),
        .word       (out_word)
    );

    assign results.valid       = out_valid;
    assign results.found       = out_word.found;
    assign results.match_begin = out_word.match_begin;
    assign results.match_end   = out_word.match_end;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !results.ready |-> !(s1_advance && has_result))
        else $error("pending result overwritten");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_word.found |-> out_word.match_begin == '0 &&
        out_word.match_end == '0)
        else $error("miss with nonzero positions");

    a_stall_holds_word: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid && !s1_advance |=> s1_valid && $stable(s1_word))
        else $error("stalled input word lost");

endmodule

`default_nettype wire

// ----- sv/masf_in_reg.sv -----
`default_nettype none

module masf_in_reg
    import masf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       load,
    input  wire char_word_t load_word,
    input  wire logic       advance,
    output logic            word_valid,
    output char_word_t      word
);

    logic       valid_reg;
    logic       valid_next;
    char_word_t word_reg;

    // holds one word; refilled in the same cycle it is consumed
    assign valid_next = load | (valid_reg & ~advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= load_word;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

`default_nettype wire

// ----- sv/masf_scan.sv -----
`default_nettype none

module masf_scan
    import masf_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         word_valid,
    input  wire char_word_t   word,
    input  wire logic [15:0]  scan_start,
    input  wire logic         advance,
    output logic              has_result,
    output result_word_t      result
);

    localparam int CMP_BITS = (POS_BITS > 16) ? POS_BITS : 16;
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    logic [POS_BITS-1:0] position_reg,   position_next;
    logic [POS_BITS-1:0] run_start_reg,  run_start_next;
    logic [POS_BITS-1:0] span_begin_reg, span_begin_next;
    logic                prev_mail_reg,  prev_mail_next;
    logic                in_domain_reg,  in_domain_next;
    logic                dot_seen_reg,   dot_seen_next;
    logic                line_done_reg,  line_done_next;

    logic                mail;
    logic                dom_keep;
    logic                dot_upd;
    logic                hit_close;
    logic                cand_open;
    logic                in_dom_b;
    logic                dot_b;
    logic [POS_BITS-1:0] span_b;
    logic [POS_BITS-1:0] pos_inc;
    logic [POS_BITS-1:0] res_begin;
    logic [POS_BITS-1:0] res_end;
    logic                res_found;
    logic [31:0]         begin_wide;
    logic [31:0]         end_wide;

    always_comb
    begin
        mail      = is_mail(word.char_code);
        pos_inc   = (position_reg == POS_MAX) ? POS_MAX : position_reg + 1'b1;
        dom_keep  = in_domain_reg & mail;
        dot_upd   = dot_seen_reg | (dom_keep & (word.char_code == DOT_CODE));
        // domain closed by a non-mail character with a dot: hit
        hit_close = in_domain_reg & ~mail & dot_seen_reg;
        // a new candidate opens on '@' after a mail run, at or past scan start
        cand_open = ~hit_close & ~dom_keep & (word.char_code == AT_CODE) &
                    prev_mail_reg &
                    (CMP_BITS'(position_reg) >= CMP_BITS'(scan_start));
        in_dom_b  = cand_open | dom_keep;
        dot_b     = cand_open ? 1'b0 : dot_upd;
        span_b    = cand_open ? run_start_reg : span_begin_reg;

        if (hit_close)
        begin
            res_found = 1'b1;
            res_begin = span_begin_reg;
            res_end   = position_reg;
        end
        else if (in_dom_b & dot_b)
        begin
            res_found = 1'b1;
            res_begin = span_b;
            res_end   = pos_inc;
        end
        else
        begin
            res_found = 1'b0;
            res_begin = '0;
            res_end   = '0;
        end

        begin_wide         = 32'(res_begin);
        end_wide           = 32'(res_end);
        result.found       = res_found;
        result.match_begin = begin_wide[15:0];
        result.match_end   = end_wide[15:0];
        has_result = word_valid & ~line_done_reg & (hit_close | word.line_end);

        position_next   = position_reg;
        run_start_next  = run_start_reg;
        span_begin_next = span_begin_reg;
        prev_mail_next  = prev_mail_reg;
        in_domain_next  = in_domain_reg;
        dot_seen_next   = dot_seen_reg;
        line_done_next  = line_done_reg;

        if (advance)
        begin
            if (word.line_end)
            begin
                position_next   = '0;
                run_start_next  = '0;
                span_begin_next = '0;
                prev_mail_next  = 1'b0;
                in_domain_next  = 1'b0;
                dot_seen_next   = 1'b0;
                line_done_next  = 1'b0;
            end
            else
            begin
                position_next = pos_inc;
                if (!line_done_reg)
                begin
                    in_domain_next  = in_dom_b;
                    dot_seen_next   = dot_b;
                    span_begin_next = span_b;
                    line_done_next  = hit_close;
                    prev_mail_next  = mail;
                    if (mail && !prev_mail_reg)
                    begin
                        run_start_next = position_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg   <= '0;
            run_start_reg  <= '0;
            span_begin_reg <= '0;
            prev_mail_reg  <= 1'b0;
            in_domain_reg  <= 1'b0;
            dot_seen_reg   <= 1'b0;
            line_done_reg  <= 1'b0;
        end
        else
        begin
            position_reg   <= position_next;
            run_start_reg  <= run_start_next;
            span_begin_reg <= span_begin_next;
            prev_mail_reg  <= prev_mail_next;
            in_domain_reg  <= in_domain_next;
            dot_seen_reg   <= dot_seen_next;
            line_done_reg  <= line_done_next;
        end
    end

    a_line_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && word.line_end |=> position_reg == '0 && !line_done_reg)
        else $error("line state not cleared at line end");

    a_done_closes_domain: assert property (@(posedge clk) disable iff (!rst_n)
        line_done_reg |-> !in_domain_reg)
        else $error("domain still open after hit");

    a_line_end_reports: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && word.line_end && !line_done_reg |-> has_result)
        else $error("line end without result");

endmodule

`default_nettype wire

// ----- sv/masf_out_reg.sv -----
`default_nettype none

module masf_out_reg
    import masf_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         load,
    input  wire result_word_t load_word,
    input  wire logic         take,
    output logic              word_valid,
    output result_word_t      word
);

    logic         valid_reg;
    logic         valid_next;
    result_word_t word_reg;

    assign valid_next = load | (valid_reg & ~take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= load_word;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

`default_nettype wire

// ----- tb/sv/mail_address_span_finder_core_tb.sv -----
`timescale 1ns / 1ps

module mail_address_span_finder_core_tb;
    import masf_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RESET_LEN   = 12;
    localparam int STALL_LIMIT = 2000;  // cycles with no word moving on any channel
    localparam int DRAIN_PAUSE = 8;     // extra margin after the last expected word
    localparam int MAX_LINE    = 40;

    // Expected-span tracker: mirrors the scan state of the core and holds
    // one expected result word per line, oldest first.
    class span_scoreboard;
        logic [15:0]  scan_start;
        logic [15:0]  position;
        logic [15:0]  run_start;
        logic [15:0]  span_begin;
        bit           prev_mail;
        bit           in_domain;
        bit           dot_seen;
        bit           line_done;
        result_word_t expected_spans[$];
        int           mismatches;

        function new();
            scan_start = '0;
            mismatches = 0;
            clear_line();
        endfunction

        function void clear_line();
            position   = '0;
            run_start  = '0;
            span_begin = '0;
            prev_mail  = 1'b0;
            in_domain  = 1'b0;
            dot_seen   = 1'b0;
            line_done  = 1'b0;
        endfunction

        function void set_scan_start(logic [15:0] v);
            scan_start = v;
        endfunction

        // Characters allowed in the local part and in the domain.
        function bit mail_char(logic [15:0] c);
            if (c >= 16'd97 && c <= 16'd122) return 1'b1;
            if (c >= 16'd65 && c <= 16'd90)  return 1'b1;
            if (c >= 16'd45 && c <= 16'd58)  return 1'b1;
            if (c >= 16'd36 && c <= 16'd38)  return 1'b1;
            return (c == 16'd126) || (c == 16'd95) || (c == 16'd92) ||
                   (c == 16'd61)  || (c == 16'd35) || (c == 16'd43);
        endfunction

        function logic [15:0] sat_inc(logic [15:0] p);
            return (p == 16'hFFFF) ? p : p + 16'd1;
        endfunction

        function void push_span(bit hit, logic [15:0] b, logic [15:0] e);
            result_word_t r;
            r.found       = hit;
            r.match_begin = hit ? b : 16'd0;
            r.match_end   = hit ? e : 16'd0;
            expected_spans.push_back(r);
        endfunction

        // One accepted character word.
        function void note_char(char_word_t w);
            logic [15:0] p;
            bit          mail;
            p = position;
            if (!line_done) begin
                mail = mail_char(w.char_code);
                if (in_domain && mail) begin
                    if (w.char_code == DOT_CODE)
                        dot_seen = 1'b1;
                end else if (in_domain) begin
                    // domain closed by a non-mail char (possibly an '@')
                    in_domain = 1'b0;
                    if (dot_seen) begin
                        push_span(1'b1, span_begin, p);
                        line_done = 1'b1;
                    end
                end
                if (!line_done && !in_domain && w.char_code == AT_CODE && prev_mail &&
                    p >= scan_start) begin
                    span_begin = run_start;
                    in_domain  = 1'b1;
                    dot_seen   = 1'b0;
                end
                if (mail && !prev_mail)
                    run_start = p;
                prev_mail = mail;
            end
            if (w.line_end) begin
                if (!line_done)
                    push_span(in_domain && dot_seen, span_begin, sat_inc(p));
                clear_line();
            end else begin
                position = sat_inc(p);
            end
        endfunction

        task report(string msg);
            mismatches++;
            $display("%0t ns MISMATCH: %s", $time, msg);
        endtask

        task check_result(result_word_t got);
            result_word_t want;
            if (expected_spans.size() == 0) begin
                report($sformatf("result word with none expected: found=%0b begin=%0d end=%0d",
                                 got.found, got.match_begin, got.match_end));
                return;
            end
            want = expected_spans.pop_front();
            if (got.found !== want.found)
                report($sformatf("found %0b, expected %0b", got.found, want.found));
            if (got.match_begin !== want.match_begin)
                report($sformatf("match_begin %0d, expected %0d",
                                 got.match_begin, want.match_begin));
            if (got.match_end !== want.match_end)
                report($sformatf("match_end %0d, expected %0d",
                                 got.match_end, want.match_end));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    masf_char_if   char_bus ();
    masf_result_if result_bus ();
    masf_cfg_if    cfg_bus ();

    mail_address_span_finder_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (char_bus),
        .results (result_bus),
        .cfg     (cfg_bus)
    );

    span_scoreboard sb = new();

    // Idle/stall knobs, percent of cycles; hold count drives the long stall.
    int send_idle_pct    = 0;
    int recv_stall_pct   = 0;
    int recv_hold_cycles = 0;
    int idle_cycles      = 0;

    logic [15:0] line_buf[$];

    always #CLK_HALF clk = ~clk;

    // ---------------------------------------------------------------
    // Character generators
    // ---------------------------------------------------------------
    function automatic logic [15:0] rand_mail_char();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4)  return 16'(97 + $urandom_range(0, 25));
        if (roll == 4) return 16'(65 + $urandom_range(0, 25));
        if (roll == 5) return 16'(48 + $urandom_range(0, 9));
        if (roll == 6) return 16'(45 + $urandom_range(0, 13));
        if (roll == 7) return 16'(36 + $urandom_range(0, 2));
        if (roll == 8) begin
            case ($urandom_range(0, 5))
                0:       return 16'd126;
                1:       return 16'd95;
                2:       return 16'd92;
                3:       return 16'd61;
                4:       return 16'd35;
                default: return 16'd43;
            endcase
        end
        return DOT_CODE;
    endfunction

    // Non-mail separators, biased to codes that sit next to the mail ranges.
    function automatic logic [15:0] rand_gap_char();
        case ($urandom_range(0, 13))
            0:       return 16'd32;
            1:       return 16'd44;
            2:       return 16'd59;
            3:       return 16'd34;
            4:       return 16'd39;
            5:       return 16'd96;
            6:       return 16'd123;
            7:       return 16'd60;
            8:       return 16'd62;
            9:       return 16'd0;
            10:      return 16'hFFFF;
            11:      return 16'd127;
            12:      return 16'(91 + 2 * $urandom_range(0, 1)); // '[' or ']'
            default: return 16'($urandom_range(16'h0100, 16'hFFFF));
        endcase
    endfunction

    // Random line: mostly address-shaped tokens, with separators, stray '@'s
    // and raw 16-bit noise mixed in.
    function automatic void build_line();
        int target;
        int roll;
        int loc_len;
        int dom_len;
        int dot_at;
        line_buf.delete();
        target = $urandom_range(1, 24);
        while (line_buf.size() < target) begin
            roll = $urandom_range(0, 19);
            if (roll < 11) begin
                loc_len = $urandom_range(0, 5);
                for (int i = 0; i < loc_len; i++)
                    line_buf.push_back(rand_mail_char());
                line_buf.push_back(AT_CODE);
                dom_len = $urandom_range(0, 6);
                dot_at  = ($urandom_range(0, 3) != 0 && dom_len > 0) ?
                          $urandom_range(0, dom_len - 1) : -1;
                for (int i = 0; i < dom_len; i++)
                    line_buf.push_back((i == dot_at) ? DOT_CODE : rand_mail_char());
                if ($urandom_range(0, 1) != 0)
                    line_buf.push_back(rand_gap_char());
            end else if (roll < 14) begin
                loc_len = $urandom_range(1, 4);
                for (int i = 0; i < loc_len; i++)
                    line_buf.push_back(rand_mail_char());
            end else if (roll < 17) begin
                line_buf.push_back(rand_gap_char());
            end else if (roll < 19) begin
                line_buf.push_back(AT_CODE);
            end else begin
                line_buf.push_back(16'($urandom_range(0, 65535)));
            end
        end
        while (line_buf.size() > MAX_LINE)
            void'(line_buf.pop_back());
    endfunction

    function automatic void load_text(string s);
        line_buf.delete();
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(16'(s[i]));
    endfunction

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------
    // Offer one character word; returns at the edge where it is taken.
    task automatic send_char(input logic [15:0] code, input logic last);
        char_word_t w;
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            char_bus.valid <= 1'b0;
            @(posedge clk);
        end
        char_bus.valid     <= 1'b1;
        char_bus.char_code <= code;
        char_bus.line_end  <= last;
        do @(posedge clk); while (!char_bus.ready);
        w.char_code = code;
        w.line_end  = last;
        sb.note_char(w);
    endtask

    task automatic send_line();
        for (int i = 0; i < line_buf.size(); i++)
            send_char(line_buf[i], i == line_buf.size() - 1);
    endtask

    task automatic run_random_lines(input int items);
        int sent;
        sent = 0;
        while (sent < items) begin
            build_line();
            send_line();
            sent += line_buf.size();
        end
        char_bus.valid <= 1'b0;
    endtask

    // Wait for every expected word, then let the pipe empty out fully:
    // trailing words after a hit produce nothing but are still in flight.
    task automatic drain();
        while (sb.expected_spans.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    task automatic write_scan_start(input logic [15:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= value;
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        sb.set_scan_start(value);
    endtask

    // ---------------------------------------------------------------
    // Result sink: samples at the edge, then picks ready for next cycle.
    // ---------------------------------------------------------------
    initial begin
        result_word_t got;
        result_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (result_bus.valid && result_bus.ready) begin
                got.found       = result_bus.found;
                got.match_begin = result_bus.match_begin;
                got.match_end   = result_bus.match_end;
                sb.check_result(got);
            end
            if (recv_hold_cycles > 0) begin
                recv_hold_cycles--;
                result_bus.ready <= 1'b0;
            end else begin
                result_bus.ready <= !(recv_stall_pct != 0 &&
                                      $urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    // Watchdog: any word moving on any channel restarts the count.
    initial begin
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((char_bus.valid && char_bus.ready) ||
                (result_bus.valid && result_bus.ready) ||
                (cfg_bus.valid && cfg_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        rst_n              <= 1'b0;
        char_bus.valid     <= 1'b0;
        char_bus.char_code <= '0;
        char_bus.line_end  <= 1'b0;
        cfg_bus.valid      <= 1'b0;
        cfg_bus.data       <= '0;
        repeat (RESET_LEN) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines, scan_start = 0, no idling.
        write_scan_start(16'd0);
        load_text("a@b.c");      // span closed by line end
        send_line();
        load_text("a@b.c d");    // closed by a non-mail char; tail ignored
        send_line();
        load_text("@.@");        // empty local part, then empty domain
        send_line();
        load_text("a@b@c.d");    // domain cut by '@', which starts a new candidate
        send_line();
        line_buf.delete();
        line_buf.push_back(16'hFFFF);  // one-char line, all bits high
        send_line();
        char_bus.valid <= 1'b0;
        drain();

        // Random phases, each under its own scan_start and idle pattern.
        write_scan_start(16'd3);
        run_random_lines(150);
        drain();

        write_scan_start(16'hFFFF);  // nothing can match on short lines
        send_idle_pct = 46;
        run_random_lines(100);
        drain();

        write_scan_start(16'($urandom_range(0, 10)));
        send_idle_pct  = 0;
        recv_stall_pct = 46;
        run_random_lines(150);
        drain();

        write_scan_start(16'($urandom_range(0, 20)));
        send_idle_pct  = 12;
        recv_stall_pct = 12;
        run_random_lines(150);
        drain();

        // Back-pressure: sink holds off while the source keeps offering.
        write_scan_start(16'd1);
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        recv_hold_cycles = 150;
        run_random_lines(100);
        drain();

        write_scan_start(16'd0);
        send_idle_pct  = 12;
        recv_stall_pct = 12;
        run_random_lines(100);
        drain();

        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/masf_pkg.sv
sv/masf_intf.sv
sv/masf_in_reg.sv
sv/masf_scan.sv
sv/masf_out_reg.sv
sv/mail_address_span_finder_core.sv
tb/sv/mail_address_span_finder_core_tb.sv
